@@ rtl/core/cac_pkg.sv @@
// Package for the analog conditioning block: widths, register and channel
// codes, filter weights, controller state and command/status structs.
// No dependencies.
package cac_pkg;

  localparam int CH_W    = 3;
  localparam int SMP_W   = 12;
  localparam int CFG_W   = 12;
  localparam int ADDR_W  = 3;
  localparam int LEVEL_W = 8;
  localparam int Q_W     = 15;   // quotient / Q8 percent width
  localparam int NUM_W   = 27;   // dividend width
  localparam int ACC_W   = 23;   // filter accumulator width
  localparam int CNT_W   = 4;

  // Register indexes
  localparam logic [ADDR_W-1:0] REG_POT_FS   = 3'd0;
  localparam logic [ADDR_W-1:0] REG_STICK_FS = 3'd1;
  localparam logic [ADDR_W-1:0] REG_DEAD     = 3'd2;
  localparam logic [ADDR_W-1:0] REG_C1X      = 3'd3;
  localparam logic [ADDR_W-1:0] REG_C1Y      = 3'd4;
  localparam logic [ADDR_W-1:0] REG_C2X      = 3'd5;
  localparam logic [ADDR_W-1:0] REG_C2Y      = 3'd6;

  // Channel codes
  localparam logic [CH_W-1:0] CH_S1X  = 3'd0;
  localparam logic [CH_W-1:0] CH_S1Y  = 3'd1;
  localparam logic [CH_W-1:0] CH_S2X  = 3'd2;
  localparam logic [CH_W-1:0] CH_S2Y  = 3'd3;
  localparam logic [CH_W-1:0] CH_POT1 = 3'd4;
  localparam logic [CH_W-1:0] CH_POT2 = 3'd5;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] POT_FS_RST   = 12'd3000;
  localparam logic [CFG_W-1:0] STICK_FS_RST = 12'd3000;
  localparam logic [CFG_W-1:0] DEAD_RST     = 12'd300;

  // Q8 percent scale and filter weights (0.7 / 0.3)
  localparam logic [Q_W-1:0]   Q8_HUNDRED = 15'd25600;
  localparam logic [ACC_W-1:0] W_OLD      = 23'd179;
  localparam logic [ACC_W-1:0] W_NEW      = 23'd77;
  localparam logic [ACC_W-1:0] Q8_HALF    = 23'd128;
  localparam logic [6:0]       PCT_MAX    = 7'd100;

  // One quotient bit per divider step
  localparam logic [CNT_W-1:0] DIV_STEPS = 4'(Q_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FILT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;     // capture the input beat
    logic prep;     // clip, center, scale, seed the divider
    logic step;     // one restoring divide step
    logic filt;     // run the pot filter
    logic finish;   // commit state, fill the output register
  } cmd_t;

  typedef struct packed {
    logic out_full; // output register holds a beat that is not taken
  } stat_t;

endpackage

@@ rtl/core/cac_in_if.sv @@
// Input channel: one converter sample beat with its channel tag.
// Depends on cac_pkg.
interface cac_in_if;
  logic                       valid;
  logic                       ready;
  logic [cac_pkg::CH_W-1:0]   channel;
  logic [cac_pkg::SMP_W-1:0]  sample;
  logic                       button_held;

  modport source (output valid, output channel, output sample, output button_held,
                  input ready);
  modport sink (input valid, input channel, input sample, input button_held,
                output ready);
endinterface

@@ rtl/core/cac_out_if.sv @@
// Output channel: one conditioned result beat.
// Depends on cac_pkg.
interface cac_out_if;
  logic                               valid;
  logic                               ready;
  logic [cac_pkg::CH_W-1:0]           out_channel;
  logic signed [cac_pkg::LEVEL_W-1:0] level;
  logic                               changed;

  modport source (output valid, output out_channel, output level, output changed,
                  input ready);
  modport sink (input valid, input out_channel, input level, input changed,
                output ready);
endinterface

@@ rtl/core/cac_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on cac_pkg.
interface cac_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cac_pkg::ADDR_W-1:0] addr;
  logic [cac_pkg::CFG_W-1:0]  data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

@@ rtl/core/cac_ctrl.sv @@
// Sequencer for the conditioning datapath: accept, setup, divide, filter,
// write result. Depends on cac_pkg.
module cac_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cac_pkg::stat_t stat,
  output cac_pkg::cmd_t  cmd
);

  cac_pkg::state_t            state, state_next;
  logic [cac_pkg::CNT_W-1:0]  cnt, cnt_next;

  // State and step counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cac_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      cac_pkg::ST_IDLE: begin
        if (in_valid) state_next = cac_pkg::ST_PREP;
      end
      cac_pkg::ST_PREP: begin
        state_next = cac_pkg::ST_DIV;
        cnt_next   = cac_pkg::DIV_STEPS - 4'd1;
      end
      cac_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = cac_pkg::ST_FILT;
        end else begin
          cnt_next = cnt - 4'd1;
        end
      end
      cac_pkg::ST_FILT: begin
        state_next = cac_pkg::ST_DONE;
      end
      cac_pkg::ST_DONE: begin
        if (!stat.out_full) state_next = cac_pkg::ST_IDLE;
      end
      default: state_next = cac_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      cac_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cac_pkg::ST_PREP: cmd.prep = 1'b1;
      cac_pkg::ST_DIV:  cmd.step = 1'b1;
      cac_pkg::ST_FILT: cmd.filt = 1'b1;
      cac_pkg::ST_DONE: cmd.finish = !stat.out_full;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/cac_datapath.sv @@
// Datapath: configuration registers, per-channel history, restoring divider,
// pot filter and output register. Depends on cac_pkg.
module cac_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  cac_pkg::cmd_t                       cmd,
  output cac_pkg::stat_t                      stat,
  // configuration writes
  input  logic                                cfg_valid,
  input  logic [cac_pkg::ADDR_W-1:0]          cfg_addr,
  input  logic [cac_pkg::CFG_W-1:0]           cfg_data,
  // input beat
  input  logic [cac_pkg::CH_W-1:0]            in_channel,
  input  logic [cac_pkg::SMP_W-1:0]           in_sample,
  input  logic                                in_button,
  // output beat
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cac_pkg::CH_W-1:0]            out_channel,
  output logic signed [cac_pkg::LEVEL_W-1:0]  out_level,
  output logic                                out_changed
);

  // Configuration
  logic [cac_pkg::CFG_W-1:0] pot_fs, stick_fs, dead_zone;
  logic [cac_pkg::CFG_W-1:0] centers [4];

  // History
  logic [cac_pkg::Q_W-1:0]             pot_filter [2];
  logic [6:0]                          pot_last [2];
  logic signed [cac_pkg::LEVEL_W-1:0]  axis_last [4];

  // Current item
  logic [cac_pkg::CH_W-1:0]  ch;
  logic [cac_pkg::SMP_W-1:0] smp;
  logic                      btn;

  // Divider and flags
  logic [cac_pkg::CFG_W-1:0] rem, den;
  logic [cac_pkg::Q_W-1:0]   quo;
  logic                      axis_neg, axis_dz, axis_hold;
  logic [cac_pkg::Q_W-1:0]   f_work;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pot_fs   <= cac_pkg::POT_FS_RST;
      stick_fs <= cac_pkg::STICK_FS_RST;
      dead_zone <= cac_pkg::DEAD_RST;
      for (int i = 0; i < 4; i++) centers[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        cac_pkg::REG_POT_FS:   pot_fs     <= cfg_data;
        cac_pkg::REG_STICK_FS: stick_fs   <= cfg_data;
        cac_pkg::REG_DEAD:     dead_zone  <= cfg_data;
        cac_pkg::REG_C1X:      centers[0] <= cfg_data;
        cac_pkg::REG_C1Y:      centers[1] <= cfg_data;
        cac_pkg::REG_C2X:      centers[2] <= cfg_data;
        cac_pkg::REG_C2Y:      centers[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Setup: clip, center, scale by 100, pick the divisor
  logic [cac_pkg::CFG_W-1:0] center, s_clip, r_clip, mag, mul_op, den_sel;
  logic                      is_axis, neg;
  logic [18:0]               prod;
  logic [cac_pkg::NUM_W-1:0] num;

  always_comb begin
    is_axis = !ch[2];
    center  = centers[ch[1:0]];
    s_clip  = (smp < stick_fs) ? smp : stick_fs;
    r_clip  = (smp < pot_fs) ? smp : pot_fs;
    neg     = s_clip < center;
    mag     = neg ? (center - s_clip) : (s_clip - center);
    mul_op  = is_axis ? mag : r_clip;
    prod    = {7'b0, mul_op} * 19'd100;
    num     = is_axis ? {8'b0, prod} : {prod, 8'b0};
    if (!is_axis)  den_sel = pot_fs;
    else if (neg)  den_sel = center;
    else           den_sel = stick_fs - center;
  end

  // Restoring divide step: one quotient bit per cycle
  logic [cac_pkg::CFG_W:0] trial, diff;
  logic                    ge;

  always_comb begin
    trial = {rem, quo[cac_pkg::Q_W-1]};
    diff  = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
  end

  // Pot filter: f = (f*179 + n*77 + 128) >> 8
  logic                       pidx;
  logic [cac_pkg::Q_W-1:0]    n_raw, n_pot, f_new;
  logic [cac_pkg::ACC_W-1:0]  acc;

  always_comb begin
    pidx  = ch[0];
    n_raw = (pot_fs == '0) ? '0 : quo;
    if (n_raw > cac_pkg::Q8_HUNDRED) n_raw = cac_pkg::Q8_HUNDRED;
    n_pot = (ch == cac_pkg::CH_POT2) ? (cac_pkg::Q8_HUNDRED - n_raw) : n_raw;
    acc   = {8'b0, pot_filter[pidx]} * cac_pkg::W_OLD
          + {8'b0, n_pot} * cac_pkg::W_NEW + cac_pkg::Q8_HALF;
    f_new = acc[cac_pkg::ACC_W-1:8];
    if (f_new > cac_pkg::Q8_HUNDRED) f_new = cac_pkg::Q8_HUNDRED;
  end

  function automatic logic signed [7:0] neg_level(input logic [6:0] q, input logic n);
    logic signed [7:0] v;
    v = {1'b0, q};
    return n ? -v : v;
  endfunction

  // Result selection
  logic [6:0]                          q7, lv;
  logic [cac_pkg::Q_W:0]               f_round;
  logic signed [cac_pkg::LEVEL_W-1:0]  axis_level, res_level;
  logic                                res_changed;

  always_comb begin
    q7         = (quo > {8'b0, cac_pkg::PCT_MAX}) ? cac_pkg::PCT_MAX : quo[6:0];
    axis_level = neg_level(q7, axis_neg);
    f_round    = {1'b0, f_work} + 16'd128;
    lv         = f_round[14:8];
    res_level   = '0;
    res_changed = 1'b0;
    case (ch)
      cac_pkg::CH_S1X, cac_pkg::CH_S1Y, cac_pkg::CH_S2X, cac_pkg::CH_S2Y: begin
        if (axis_hold) begin
          res_level   = axis_last[ch[1:0]];
          res_changed = 1'b1;
        end else if (axis_dz) begin
          res_level   = '0;
          res_changed = axis_last[ch[1:0]] != '0;
        end else begin
          res_level   = axis_level;
          res_changed = 1'b1;
        end
      end
      cac_pkg::CH_POT1, cac_pkg::CH_POT2: begin
        res_level   = {1'b0, lv};
        res_changed = lv != pot_last[pidx];
      end
      default: begin
        res_level   = '0;
        res_changed = 1'b0;
      end
    endcase
  end

  // Item capture, divider and filter registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch  <= in_channel;
      smp <= in_sample;
      btn <= in_button;
    end
    if (cmd.prep) begin
      rem       <= num[cac_pkg::NUM_W-1:cac_pkg::Q_W];
      quo       <= num[cac_pkg::Q_W-1:0];
      den       <= den_sel;
      axis_neg  <= neg;
      axis_dz   <= mag <= dead_zone;
      axis_hold <= btn && is_axis && !ch[0];
    end else if (cmd.step) begin
      rem <= ge ? diff[cac_pkg::CFG_W-1:0] : trial[cac_pkg::CFG_W-1:0];
      quo <= {quo[cac_pkg::Q_W-2:0], ge};
    end
    if (cmd.filt) f_work <= f_new;
  end

  // History update at the end of an item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) axis_last[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        pot_filter[i] <= '0;
        pot_last[i]   <= '0;
      end
    end else if (cmd.finish) begin
      case (ch)
        cac_pkg::CH_S1X, cac_pkg::CH_S1Y, cac_pkg::CH_S2X, cac_pkg::CH_S2Y: begin
          if (!axis_hold) axis_last[ch[1:0]] <= axis_dz ? '0 : axis_level;
        end
        cac_pkg::CH_POT1, cac_pkg::CH_POT2: begin
          pot_filter[pidx] <= f_work;
          pot_last[pidx]   <= lv;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_channel <= ch;
      out_level   <= res_level;
      out_changed <= res_changed;
    end
  end

  assign stat.out_full = out_valid && !out_ready;

endmodule

@@ rtl/core/controller_analog_conditioning.sv @@
// Top level of the analog conditioning block: sequencer plus datapath.
// Depends on cac_pkg, cac_in_if, cac_out_if, cac_cfg_if, cac_ctrl, cac_datapath.
//
// Usage:
//  samples : valid/ready input, one beat per converter reading (channel,
//            sample, button_held). Channels 0..3 are stick axes, 4 and 5 pots.
//  results : valid/ready output, one beat per input beat (out_channel, level,
//            changed), in input order.
//  cfg     : valid/ready register writes (addr, data); always ready. Write
//            only while no item is in flight.
//  Steps   : from input accept to result valid: a setup state, 15 restoring
//            divide steps, a filter state and the write.
//  Rate    : one item at a time; the next beat is taken only in the idle
//            state that follows the write. The divider yields one quotient
//            bit per cycle.
//  Stall   : the result sits in an output register. A new sample is taken
//            while it waits; that item then holds before its write until
//            the previous result is taken.
//  Reset   : rst (synchronous) restores register defaults (full scales 3000,
//            dead zone 300, centers 0) and clears filters and histories.
module controller_analog_conditioning (
  input logic       clk,
  input logic       rst,
  cac_in_if.sink    samples,
  cac_out_if.source results,
  cac_cfg_if.sink   cfg
);

  cac_pkg::cmd_t  cmd;
  cac_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  cac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cac_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_valid   (cfg.valid),
    .cfg_addr    (cfg.addr),
    .cfg_data    (cfg.data),
    .in_channel  (samples.channel),
    .in_sample   (samples.sample),
    .in_button   (samples.button_held),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_channel (results.out_channel),
    .out_level   (results.level),
    .out_changed (results.changed)
  );

endmodule

@@ verif/cac_conditioning_checker.sv @@
// Result checker for the analog conditioning block: tracks register writes,
// predicts each result beat and compares it with what the block returns.
// Depends on cac_pkg, cac_in_if, cac_out_if, cac_cfg_if.
module cac_conditioning_checker (
  input  logic clk,
  input  logic rst,
  cac_in_if    smp,
  cac_out_if   res,
  cac_cfg_if   cfg,
  output int   fail_count,
  output int   pending,
  output int   results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import cac_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0]           ch;
    logic signed [LEVEL_W-1:0] level;
    logic                      changed;
  } cond_result_t;

  // Register shadow
  logic [CFG_W-1:0] pot_fs;
  logic [CFG_W-1:0] stick_fs;
  logic [CFG_W-1:0] dead_band;
  logic [CFG_W-1:0] rest_pos [4];

  // Filter and history shadow
  logic [Q_W-1:0]            pot_smooth [2];
  logic [6:0]                pot_pct_prev [2];
  logic signed [LEVEL_W-1:0] axis_prev [4];

  cond_result_t expected_q [$];

  task automatic report(input string msg);
    if (fail_count < 50)
      $display("ERROR @%0t: %s", $time, msg);
    fail_count = fail_count + 1;
  endtask

  // Compute the result of one sample and advance the shadow state
  function automatic cond_result_t condition_sample(input logic [CH_W-1:0] ch,
                                                    input logic [SMP_W-1:0] raw,
                                                    input logic btn);
    cond_result_t r;
    int clipped, centred, mag, span, pct, norm, filt, rounded, ax, idx, q8;
    r.ch      = ch;
    r.level   = '0;
    r.changed = 1'b0;
    q8        = int'(Q8_HUNDRED);
    if (ch <= CH_S2Y) begin
      ax      = int'(ch[1:0]);
      clipped = (raw < stick_fs) ? int'(raw) : int'(stick_fs);
      centred = clipped - int'(rest_pos[ax]);
      mag     = (centred < 0) ? -centred : centred;
      if (btn && (ch == CH_S1X || ch == CH_S2X)) begin
        // hold the last x deflection while the stick button is down
        r.level   = axis_prev[ax];
        r.changed = 1'b1;
      end else if (mag <= int'(dead_band)) begin
        r.changed     = (axis_prev[ax] != 0);
        axis_prev[ax] = '0;
      end else begin
        if (centred > 0) begin
          span = int'(stick_fs) - int'(rest_pos[ax]);
        end else begin
          span = int'(rest_pos[ax]);
        end
        pct = (span > 0) ? (centred * 100) / span : 0;
        if (pct > 100) pct = 100;
        else if (pct < -100) pct = -100;
        axis_prev[ax] = LEVEL_W'(pct);
        r.level       = LEVEL_W'(pct);
        r.changed     = 1'b1;
      end
    end else if (ch == CH_POT1 || ch == CH_POT2) begin
      idx     = (ch == CH_POT2) ? 1 : 0;
      clipped = (raw < pot_fs) ? int'(raw) : int'(pot_fs);
      norm    = (pot_fs != '0) ? (clipped * q8) / int'(pot_fs) : 0;
      if (norm > q8) norm = q8;
      if (idx == 1) norm = q8 - norm;
      filt = (int'(pot_smooth[idx]) * int'(W_OLD) + norm * int'(W_NEW)
              + int'(Q8_HALF)) >> 8;
      if (filt > q8) filt = q8;
      pot_smooth[idx]   = Q_W'(filt);
      rounded           = (filt + int'(Q8_HALF)) >> 8;
      r.changed         = (rounded != int'(pot_pct_prev[idx]));
      pot_pct_prev[idx] = 7'(rounded);
      r.level           = LEVEL_W'(rounded);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cond_result_t want;
    cond_result_t got;
    if (rst) begin
      pot_fs    = POT_FS_RST;
      stick_fs  = STICK_FS_RST;
      dead_band = DEAD_RST;
      for (int i = 0; i < 4; i++) begin
        rest_pos[i]  = '0;
        axis_prev[i] = '0;
      end
      for (int i = 0; i < 2; i++) begin
        pot_smooth[i]   = '0;
        pot_pct_prev[i] = '0;
      end
      expected_q.delete();
    end else begin
      // track register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          REG_POT_FS:   pot_fs      = cfg.data;
          REG_STICK_FS: stick_fs    = cfg.data;
          REG_DEAD:     dead_band   = cfg.data;
          REG_C1X:      rest_pos[0] = cfg.data;
          REG_C1Y:      rest_pos[1] = cfg.data;
          REG_C2X:      rest_pos[2] = cfg.data;
          REG_C2Y:      rest_pos[3] = cfg.data;
          default: ;
        endcase
      end
      // compare a result beat with the oldest expectation
      if (res.valid && res.ready) begin
        got = '{res.out_channel, res.level, res.changed};
        results_seen = results_seen + 1;
        if (expected_q.size() == 0) begin
          report($sformatf("result with nothing expected: ch %0d level %0d changed %0b",
                           got.ch, got.level, got.changed));
        end else begin
          want = expected_q.pop_front();
          if (got.ch !== want.ch)
            report($sformatf("out_channel got %0d expected %0d", got.ch, want.ch));
          if (got.level !== want.level)
            report($sformatf("level on ch %0d got %0d expected %0d",
                             want.ch, got.level, want.level));
          if (got.changed !== want.changed)
            report($sformatf("changed on ch %0d got %0b expected %0b",
                             want.ch, got.changed, want.changed));
        end
      end
      // predict the sample beat accepted at this edge
      if (smp.valid && smp.ready)
        expected_q.push_back(condition_sample(smp.channel, smp.sample, smp.button_held));
    end
    pending <= expected_q.size();
  end

endmodule

@@ verif/tb_controller_analog_conditioning.sv @@
// Testbench top for the analog conditioning block: clock, reset, sample and
// register stimulus, result back-pressure and the final verdict.
// Depends on cac_pkg, the three channel interfaces and cac_conditioning_checker.
module tb_controller_analog_conditioning;
  timeunit 1ns;
  timeprecision 1ps;
  import cac_pkg::*;

  localparam logic [CH_W-1:0] CH_SPARE_LO = 3'd6;
  localparam logic [CH_W-1:0] CH_SPARE_HI = 3'd7;
  localparam int NUM_PHASES    = 7;
  localparam int PHASE_ITEMS   = 250;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SMP_MAX       = 4095;

  logic clk;
  logic rst;

  cac_in_if  smp_if ();
  cac_out_if res_if ();
  cac_cfg_if cfg_if ();

  int fail_count;
  int pending;
  int results_seen;

  // Stimulus controls shared with the result-side process
  logic idle_on;
  logic rx_hold_req;

  int cur_cfg [8];
  int last_smp [8];
  int sent_items;
  int settings_loaded;

  logic [ADDR_W-1:0] reg_order [7] = '{REG_POT_FS, REG_STICK_FS, REG_DEAD,
                                       REG_C1X, REG_C1Y, REG_C2X, REG_C2Y};

  controller_analog_conditioning dut (
    .clk     (clk),
    .rst     (rst),
    .samples (smp_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  cac_conditioning_checker chk (
    .clk          (clk),
    .rst          (rst),
    .smp          (smp_if),
    .res          (res_if),
    .cfg          (cfg_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #5_000_000;
    $display("controller_analog_conditioning: mismatch");
    $finish;
  end

  // Result side: random stall bursts plus one long hold on request
  initial begin : result_ready
    int   stall_left;
    logic hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (rx_hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = RX_HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Offer one sample beat; returns at the falling edge after acceptance
  task automatic offer(input logic [CH_W-1:0] ch, input int raw, input logic btn);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      smp_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp_if.valid       <= 1'b1;
    smp_if.channel     <= ch;
    smp_if.sample      <= SMP_W'(raw);
    smp_if.button_held <= btn;
    @(posedge clk);
    while (!smp_if.ready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_idle();
    smp_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Write all seven registers from cur_cfg
  task automatic load_settings();
    for (int i = 0; i < 7; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.addr  <= reg_order[i];
      cfg_if.data  <= CFG_W'(cur_cfg[reg_order[i]]);
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic set_cfg(input int pfs, input int sfs, input int dz,
                         input int c0, input int c1, input int c2, input int c3);
    cur_cfg[REG_POT_FS]   = pfs;
    cur_cfg[REG_STICK_FS] = sfs;
    cur_cfg[REG_DEAD]     = dz;
    cur_cfg[REG_C1X]      = c0;
    cur_cfg[REG_C1Y]      = c1;
    cur_cfg[REG_C2X]      = c2;
    cur_cfg[REG_C2Y]      = c3;
  endtask

  function automatic int clamp_smp(input int v);
    return (v < 0) ? 0 : ((v > SMP_MAX) ? SMP_MAX : v);
  endfunction

  // Choose register values for one random phase; the first two are the extremes
  task automatic pick_settings(input int ph);
    int sfs, mid;
    sfs = $urandom_range(1200, SMP_MAX);
    mid = sfs / 2;
    case (ph)
      0: set_cfg(SMP_MAX, SMP_MAX, 0, 0, SMP_MAX, 2048, 1);
      1: set_cfg(1, 1, 0, 0, 1, 0, 1);
      4: set_cfg($urandom_range(1, SMP_MAX), sfs, SMP_MAX,
                 $urandom_range(0, SMP_MAX), $urandom_range(0, SMP_MAX),
                 $urandom_range(0, SMP_MAX), $urandom_range(0, SMP_MAX));
      5: set_cfg($urandom_range(1, SMP_MAX), sfs, $urandom_range(0, 200),
                 $urandom_range(0, SMP_MAX), $urandom_range(0, SMP_MAX),
                 $urandom_range(0, SMP_MAX), $urandom_range(0, SMP_MAX));
      default: set_cfg($urandom_range(1, SMP_MAX), sfs, $urandom_range(0, 400),
                       clamp_smp(mid + int'($urandom_range(0, 800)) - 400),
                       clamp_smp(mid + int'($urandom_range(0, 800)) - 400),
                       clamp_smp(mid + int'($urandom_range(0, 800)) - 400),
                       clamp_smp(mid + int'($urandom_range(0, 800)) - 400));
    endcase
  endtask

  // Sample value: extremes, dead-zone edges (full-scale edge for pots), slow drift or uniform
  function automatic int pick_sample(input logic [CH_W-1:0] ch);
    int mode, v, ctr, span;
    mode = $urandom_range(0, 9);
    if (ch <= CH_S2Y) begin
      ctr  = cur_cfg[REG_C1X + ch];
      span = cur_cfg[REG_DEAD];
    end else begin
      ctr  = cur_cfg[REG_POT_FS];
      span = 4;
    end
    case (mode)
      0:       v = 0;
      1:       v = SMP_MAX;
      2, 3:    v = ctr + int'($urandom_range(0, 2 * span + 4)) - span - 2;
      4, 5, 6: v = last_smp[ch] + int'($urandom_range(0, 16)) - 8;
      default: v = $urandom_range(0, SMP_MAX);
    endcase
    v = clamp_smp(v);
    last_smp[ch] = v;
    return v;
  endfunction

  initial begin : stimulus
    int counted;
    logic [CH_W-1:0] ch;
    rst                = 1'b1;
    idle_on            = 1'b0;
    rx_hold_req        = 1'b0;
    sent_items         = 0;
    settings_loaded    = 0;
    smp_if.valid       = 1'b0;
    smp_if.channel     = '0;
    smp_if.sample      = '0;
    smp_if.button_held = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.addr        = '0;
    cfg_if.data        = '0;
    foreach (last_smp[i]) last_smp[i] = 0;
    set_cfg(int'(POT_FS_RST), int'(STICK_FS_RST), int'(DEAD_RST), 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: register defaults after reset
    idle_on = 1'b1;
    offer(CH_S1X, 0, 1'b0);          // rest, nothing to report
    offer(CH_S1X, SMP_MAX, 1'b0);    // clipped at full scale
    offer(CH_S1X, 0, 1'b1);          // button freezes x
    offer(CH_S1X, 0, 1'b0);          // return to zero reports a change
    offer(CH_S1Y, SMP_MAX, 1'b1);    // button has no effect on y
    offer(CH_S1Y, 300, 1'b0);        // dead-zone edge, y return to zero
    offer(CH_S2X, 1500, 1'b0);
    offer(CH_S2X, SMP_MAX, 1'b1);
    offer(CH_S2Y, 301, 1'b0);
    offer(CH_POT1, SMP_MAX, 1'b0);
    offer(CH_POT1, SMP_MAX, 1'b1);
    offer(CH_POT2, 0, 1'b0);
    offer(CH_POT2, SMP_MAX, 1'b0);
    offer(CH_SPARE_LO, SMP_MAX, 1'b1);
    offer(CH_SPARE_HI, 12'hAAA, 1'b0);
    wait_idle();

    // Directed: full-range scales, no dead zone, centers at 2048, 0, 4095 and 1000
    set_cfg(SMP_MAX, SMP_MAX, 0, 2048, 0, SMP_MAX, 1000);
    load_settings();
    offer(CH_S1X, 0, 1'b0);          // full negative
    offer(CH_S1X, 2047, 1'b0);       // truncates to zero outside dead zone
    offer(CH_S1Y, 0, 1'b0);          // center at zero
    offer(CH_S2X, SMP_MAX, 1'b0);    // center at top
    offer(CH_S2X, 0, 1'b0);
    offer(CH_S2Y, SMP_MAX, 1'b0);
    offer(CH_S2Y, 500, 1'b0);
    wait_idle();

    // Directed: zero pot full scale, widest dead zone
    set_cfg(0, 1, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
    load_settings();
    offer(CH_POT1, 2000, 1'b0);
    offer(CH_POT2, 2000, 1'b0);
    offer(CH_S1Y, SMP_MAX, 1'b0);
    wait_idle();

    // Random phases, each with its own register settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      pick_settings(ph);
      load_settings();
      idle_on = (ph != NUM_PHASES - 1);
      if (ph == 2) rx_hold_req = 1'b1;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 2) begin
          ch = CH_W'($urandom_range(int'(CH_SPARE_LO), int'(CH_SPARE_HI)));
        end else begin
          ch = CH_W'($urandom_range(int'(CH_S1X), int'(CH_POT2)));
          counted++;
        end
        offer(ch, pick_sample(ch), $urandom_range(0, 3) == 0);
        // let everything drain once mid-phase
        if (ph == 3 && counted == PHASE_ITEMS / 2) wait_idle();
      end
      wait_idle();
    end

    repeat (40) @(negedge clk);
    $display("Covered %0d sample beats under %0d register settings plus reset defaults,",
             sent_items, settings_loaded);
    $display("  %0d results checked, %0d failures", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("controller_analog_conditioning: match");
    end else begin
      $display("controller_analog_conditioning: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cac_pkg.sv
rtl/core/cac_in_if.sv
rtl/core/cac_out_if.sv
rtl/core/cac_cfg_if.sv
rtl/core/cac_ctrl.sv
rtl/core/cac_datapath.sv
rtl/core/controller_analog_conditioning.sv
verif/cac_conditioning_checker.sv
verif/tb_controller_analog_conditioning.sv
